[sv/casp_pkg.sv]
// Shared types and constants for the CIGAR affine-gap score block.
// Used by the configuration registers, the shared divider and the top level.
`timescale 1ns / 1ps

package casp_pkg;

	localparam int LENGTH_BITS_DEF       = 16;
	localparam int PERCENT_FRAC_BITS_DEF = 8;

	localparam int PERCENT_SCALE = 100;

	localparam logic [2:0] OP_MATCH    = 3'd0;
	localparam logic [2:0] OP_MISMATCH = 3'd1;
	localparam logic [2:0] OP_INSERT   = 3'd2;
	localparam logic [2:0] OP_DELETE   = 3'd3;
	localparam logic [2:0] OP_SOFTCLIP = 3'd4;

	localparam logic [1:0] REG_MATCH_AWARD      = 2'd0;
	localparam logic [1:0] REG_MISMATCH_PENALTY = 2'd1;
	localparam logic [1:0] REG_GAP_OPEN         = 2'd2;
	localparam logic [1:0] REG_GAP_EXTEND       = 2'd3;

	localparam logic [7:0] MATCH_AWARD_RST      = 8'd1;
	localparam logic [7:0] MISMATCH_PENALTY_RST = 8'd4;
	localparam logic [7:0] GAP_OPEN_RST         = 8'd6;
	localparam logic [7:0] GAP_EXTEND_RST       = 8'd1;

	localparam logic [5:0] DIV_NARROW_BITS = 6'd16;
	localparam logic [5:0] DIV_WIDE_BITS   = 6'd32;

	typedef struct packed {
		logic [2:0]  op_kind;
		logic [15:0] op_length;
		logic        node_end;
		logic        read_end;
		logic [15:0] read_length;
	} casp_in_t;

	typedef struct packed {
		logic [15:0] node_percent;
		logic        node_fault;
		logic        read_done;
		logic [31:0] read_percent_q8;
		logic        read_fault;
	} casp_out_t;

	typedef struct packed {
		logic [7:0] match_award;
		logic [7:0] mismatch_penalty;
		logic [7:0] gap_open_penalty;
		logic [7:0] gap_extend_penalty;
	} casp_cfg_t;

	typedef struct packed {
		logic start;
		logic wide;
	} casp_div_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} casp_div_rsp_t;

endpackage

[sv/casp_cfg.sv]
// APB-style register file holding the four scoring weights.
// Depends on casp_pkg for register indexes, reset values and the weight struct.
`timescale 1ns / 1ps

module casp_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output casp_pkg::casp_cfg_t  cfg
);
	import casp_pkg::*;

	casp_cfg_t cfg_q;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_award        <= MATCH_AWARD_RST;
			cfg_q.mismatch_penalty   <= MISMATCH_PENALTY_RST;
			cfg_q.gap_open_penalty   <= GAP_OPEN_RST;
			cfg_q.gap_extend_penalty <= GAP_EXTEND_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MATCH_AWARD:      cfg_q.match_award        <= pwdata[7:0];
				REG_MISMATCH_PENALTY: cfg_q.mismatch_penalty   <= pwdata[7:0];
				REG_GAP_OPEN:         cfg_q.gap_open_penalty   <= pwdata[7:0];
				REG_GAP_EXTEND:       cfg_q.gap_extend_penalty <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MATCH_AWARD:      prdata = {24'd0, cfg_q.match_award};
			REG_MISMATCH_PENALTY: prdata = {24'd0, cfg_q.mismatch_penalty};
			REG_GAP_OPEN:         prdata = {24'd0, cfg_q.gap_open_penalty};
			REG_GAP_EXTEND:       prdata = {24'd0, cfg_q.gap_extend_penalty};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

[sv/casp_div.sv]
// Shared restoring radix-2 divider, one quotient bit per cycle, 16 or 32 quotient bits.
// A quotient that would not fit is flagged as saturated. Depends on casp_pkg.
`timescale 1ns / 1ps

module casp_div #(
	parameter int NUM_W = 47
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  casp_pkg::casp_div_req_t  req,
	input  logic [NUM_W-1:0]         num,
	input  logic [31:0]              den,
	output casp_pkg::casp_div_rsp_t  rsp,
	output logic [31:0]              quo
);
	import casp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             sat_q;
	logic [5:0]       cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      sh_q;
	logic [NUM_W-1:0] hi;
	logic             over;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic             fits;

	assign hi    = req.wide ? (num >> DIV_WIDE_BITS) : (num >> DIV_NARROW_BITS);
	assign over  = hi >= NUM_W'(den);
	assign trial = {rem_q, sh_q[31]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign quo      = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= (req.start && over) || (!req.start && busy_q && (cnt_q == 6'd1));
			if (req.start) begin
				sat_q <= over;
				if (!over) begin
					busy_q <= 1'b1;
					cnt_q  <= req.wide ? DIV_WIDE_BITS : DIV_NARROW_BITS;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= hi[31:0];
			sh_q  <= req.wide ? num[31:0] : {num[15:0], 16'd0};
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : trial[31:0];
			sh_q  <= {sh_q[30:0], fits};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q || done_q)
		else $error("divider start neither ran nor finished");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !busy_q && cnt_q <= DIV_WIDE_BITS)
		else $error("divider done while still iterating");

endmodule

[sv/cigar_affine_score_percent.sv]
// Affine-gap alignment score of CIGAR elements, reported as a percent per node and per read.
// Elements arrive on the item channel (item_valid, item_stall, item); a transfer takes
// place at a rising edge with valid high and stall low. Each element that ends a node or a
// read yields one transfer on the result channel (result_valid, result_stall, result);
// other elements yield none. Scoring weights sit in four 8-bit registers on the APB
// port at byte addresses 0, 4, 8 and 12 (match, mismatch, gap open, gap extend).
// The block works on one element at a time and holds item_stall high meanwhile.
// An element that does not end a node passes through a multiply and an accumulate step.
// A node end adds a division with a 16-bit quotient on the shared radix-2 divider; an
// empty or fully clipped node skips the divider. A read end adds a division with a
// 32-bit quotient, skipped when the read is faulted. A saturating quotient leaves
// the division without iterating.
// A finished result waits in an output register while the next element is taken; if
// result_stall is still high when the following result is ready, the block holds there.
// Reset clears all scores, lengths and clip totals and loads the default weights.
// Depends on casp_pkg, casp_cfg and casp_div.
`timescale 1ns / 1ps

module cigar_affine_score_percent #(
	parameter int LENGTH_BITS       = casp_pkg::LENGTH_BITS_DEF,
	parameter int PERCENT_FRAC_BITS = casp_pkg::PERCENT_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  casp_pkg::casp_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output casp_pkg::casp_out_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import casp_pkg::*;

	localparam int         LenW    = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
	localparam logic [15:0] LenMask = 16'((33'd1 << LenW) - 33'd1);
	localparam int         NumW    = 39 + PERCENT_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_NODE, ST_NODE_DIV, ST_READ, ST_READ_DIV, ST_OUT
	} state_t;

	state_t        state_q;
	casp_cfg_t     cfg;
	casp_in_t      item_q;
	logic [23:0]   prod_q;
	logic [31:0]   score_q;
	logic [31:0]   len_acc_q;
	logic [31:0]   clip_acc_q;
	logic [31:0]   rscore_q;
	logic [31:0]   rclip_q;
	casp_out_t     res_q;
	casp_out_t     result_q;
	logic          result_valid_q;
	logic          div_start_q;
	logic          div_wide_q;
	logic [NumW-1:0] div_num_q;
	logic [31:0]   div_den_q;
	casp_div_req_t div_req;
	casp_div_rsp_t div_rsp;
	logic [31:0]   div_quo;

	logic          is_gap;
	logic          is_neg;
	logic [7:0]    fac_a;
	logic [15:0]   fac_b;
	logic [24:0]   mag;
	logic [32:0]   sum;
	logic [31:0]   score_sat;
	logic [30:0]   score_pos;
	logic [32:0]   len_sum;
	logic [32:0]   clip_sum;
	logic [32:0]   rscore_sum;
	logic [32:0]   rclip_sum;
	logic          node_empty;
	logic          node_all_clip;
	logic          read_short;
	logic          out_free;
	logic          accept;
	logic          node_close;

	casp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign div_req.start = div_start_q;
	assign div_req.wide  = div_wide_q;

	casp_div #(
		.NUM_W (NumW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num_q),
		.den    (div_den_q),
		.rsp    (div_rsp),
		.quo    (div_quo)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;
	assign node_close   = item_q.node_end || item_q.read_end;

	always_comb begin
		is_gap = (item_q.op_kind == OP_INSERT) || (item_q.op_kind == OP_DELETE);
		is_neg = is_gap || (item_q.op_kind == OP_MISMATCH);
		case (item_q.op_kind)
			OP_MATCH:    fac_a = cfg.match_award;
			OP_MISMATCH: fac_a = cfg.mismatch_penalty;
			OP_INSERT:   fac_a = cfg.gap_extend_penalty;
			OP_DELETE:   fac_a = cfg.gap_extend_penalty;
			default:     fac_a = 8'd0;
		endcase
		if (is_gap) begin
			fac_b = (item_q.op_length == 16'd0) ? 16'd0 : item_q.op_length - 16'd1;
		end else begin
			fac_b = item_q.op_length;
		end
	end

	always_comb begin
		mag = {1'b0, prod_q} + (is_gap ? {17'd0, cfg.gap_open_penalty} : 25'd0);
		if (is_neg) begin
			sum = {score_q[31], score_q} - {8'd0, mag};
		end else begin
			sum = {score_q[31], score_q} + {8'd0, mag};
		end
		if (sum[32] != sum[31]) begin
			score_sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			score_sat = sum[31:0];
		end
		score_pos     = score_q[31] ? 31'd0 : score_q[30:0];
		len_sum       = {1'b0, len_acc_q} + {17'd0, item_q.op_length};
		clip_sum      = {1'b0, clip_acc_q} + {17'd0, item_q.op_length};
		rscore_sum    = {1'b0, rscore_q} + {2'd0, score_pos};
		rclip_sum     = {1'b0, rclip_q} + {1'b0, clip_acc_q};
		node_empty    = (len_acc_q == 32'd0);
		node_all_clip = (clip_acc_q >= len_acc_q);
		read_short    = ({16'd0, item_q.read_length} <= rclip_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			div_start_q    <= 1'b0;
			div_wide_q     <= 1'b0;
			score_q        <= 32'd0;
			len_acc_q      <= 32'd0;
			clip_acc_q     <= 32'd0;
			rscore_q       <= 32'd0;
			rclip_q        <= 32'd0;
		end else begin
			div_start_q <= ((state_q == ST_NODE) && !node_empty && !node_all_clip)
				|| ((state_q == ST_READ) && !read_short);
			if ((state_q == ST_OUT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					score_q   <= score_sat;
					len_acc_q <= len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
					if (item_q.op_kind == OP_SOFTCLIP) begin
						clip_acc_q <= clip_sum[32] ? 32'hFFFF_FFFF : clip_sum[31:0];
					end
					state_q <= node_close ? ST_NODE : ST_IDLE;
				end
				ST_NODE: begin
					rscore_q   <= rscore_sum[32] ? 32'hFFFF_FFFF : rscore_sum[31:0];
					rclip_q    <= rclip_sum[32] ? 32'hFFFF_FFFF : rclip_sum[31:0];
					score_q    <= 32'd0;
					len_acc_q  <= 32'd0;
					clip_acc_q <= 32'd0;
					if (!node_empty && !node_all_clip) begin
						div_wide_q <= 1'b0;
						state_q    <= ST_NODE_DIV;
					end else begin
						state_q <= item_q.read_end ? ST_READ : ST_OUT;
					end
				end
				ST_NODE_DIV: begin
					if (div_rsp.done) begin
						state_q <= item_q.read_end ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					rscore_q <= 32'd0;
					rclip_q  <= 32'd0;
					if (read_short) begin
						state_q <= ST_OUT;
					end else begin
						div_wide_q <= 1'b1;
						state_q    <= ST_READ_DIV;
					end
				end
				ST_READ_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op_kind     <= item.op_kind;
			item_q.op_length   <= item.op_length & LenMask;
			item_q.node_end    <= item.node_end;
			item_q.read_end    <= item.read_end;
			item_q.read_length <= item.read_length & LenMask;
		end
		if (state_q == ST_MUL) begin
			prod_q <= 24'(fac_a) * 24'(fac_b);
		end
		if (state_q == ST_NODE) begin
			res_q.node_percent    <= 16'd0;
			res_q.node_fault      <= !node_empty && node_all_clip;
			res_q.read_done       <= item_q.read_end;
			res_q.read_percent_q8 <= 32'd0;
			res_q.read_fault      <= 1'b0;
			div_num_q             <= NumW'(score_pos) * NumW'(PERCENT_SCALE);
			div_den_q             <= len_acc_q - clip_acc_q;
		end
		if (state_q == ST_NODE_DIV && div_rsp.done) begin
			res_q.node_percent <= div_rsp.sat ? 16'hFFFF : div_quo[15:0];
		end
		if (state_q == ST_READ) begin
			res_q.read_fault <= read_short;
			div_num_q        <= (NumW'(rscore_q) * NumW'(PERCENT_SCALE)) << PERCENT_FRAC_BITS;
			div_den_q        <= {16'd0, item_q.read_length} - rclip_q;
		end
		if (state_q == ST_READ_DIV && div_rsp.done) begin
			res_q.read_percent_q8 <= div_rsp.sat ? 32'hFFFF_FFFF : div_quo;
		end
		if (state_q == ST_OUT && out_free) begin
			result_q <= res_q;
		end
	end

	a_node_only_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.read_done |-> result.read_percent_q8 == 32'd0 && !result.read_fault)
		else $error("read fields set on a node-only result");

	a_node_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.node_fault |-> result.node_percent == 16'd0)
		else $error("node percent nonzero on a faulted node");

	a_read_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_fault |-> result.read_percent_q8 == 32'd0 && result.read_done)
		else $error("read percent nonzero on a faulted read");

endmodule

[tb/casp_score_monitor.sv]
// Score monitor for the CIGAR affine-gap score block: it watches the element, result
// and APB channels, predicts every result and compares it field by field.
// Depends on casp_pkg for the transfer types, operation codes and register indexes.
`timescale 1ns / 1ps

module casp_score_monitor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  casp_pkg::casp_in_t  item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  casp_pkg::casp_out_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending
);
	import casp_pkg::*;

	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
	localparam longint U32_MAX = 64'sh0000_0000_FFFF_FFFF;
	localparam longint U16_MAX = 64'sh0000_0000_0000_FFFF;

	logic [7:0] match_w;
	logic [7:0] mismatch_w;
	logic [7:0] open_w;
	logic [7:0] extend_w;

	logic signed [31:0] node_score;
	logic [31:0] node_len;
	logic [31:0] node_clip;
	logic [31:0] read_score;
	logic [31:0] read_clip;

	casp_out_t awaited[$];
	int error_count;

	function automatic logic [31:0] add_sat32(input logic [31:0] a, input longint b);
		longint s;
		s = longint'(a) + b;
		return (s > U32_MAX) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic score_element(input casp_in_t el);
		longint len;
		longint ext;
		longint delta;
		longint sum;
		longint score;
		longint divisor;
		longint quotient;
		casp_out_t res;
		len = longint'(el.op_length);
		delta = 0;
		case (el.op_kind)
			OP_MATCH: delta = longint'(match_w) * len;
			OP_MISMATCH: delta = -(longint'(mismatch_w) * len);
			OP_INSERT, OP_DELETE: begin
				ext = (len > 0) ? len - 1 : 0;
				delta = -(longint'(open_w) + longint'(extend_w) * ext);
			end
			OP_SOFTCLIP: node_clip = add_sat32(node_clip, len);
			default: ;
		endcase
		sum = longint'(node_score) + delta;
		if (sum > S32_MAX) begin
			node_score = S32_MAX[31:0];
		end else if (sum < S32_MIN) begin
			node_score = S32_MIN[31:0];
		end else begin
			node_score = sum[31:0];
		end
		node_len = add_sat32(node_len, len);
		if (!(el.node_end || el.read_end)) begin
			return;
		end

		res = '0;
		score = (node_score < 0) ? 0 : longint'(node_score);
		if (node_len != 0) begin
			if (node_clip >= node_len) begin
				res.node_fault = 1'b1;
			end else begin
				divisor = longint'(node_len) - longint'(node_clip);
				quotient = (score * PERCENT_SCALE) / divisor;
				res.node_percent = (quotient > U16_MAX) ? 16'hFFFF : quotient[15:0];
			end
		end
		read_score = add_sat32(read_score, score);
		read_clip = add_sat32(read_clip, longint'(node_clip));
		node_score = '0;
		node_len = '0;
		node_clip = '0;

		if (el.read_end) begin
			res.read_done = 1'b1;
			if (longint'(el.read_length) <= longint'(read_clip)) begin
				res.read_fault = 1'b1;
			end else begin
				divisor = longint'(el.read_length) - longint'(read_clip);
				quotient = ((longint'(read_score) * PERCENT_SCALE) << PERCENT_FRAC_BITS_DEF)
					/ divisor;
				res.read_percent_q8 = (quotient > U32_MAX) ? 32'hFFFF_FFFF : quotient[31:0];
			end
			read_score = '0;
			read_clip = '0;
		end
		awaited.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	task automatic compare_result(input casp_out_t got);
		casp_out_t want;
		if (awaited.size() == 0) begin
			$error("result transfer %h with no score awaited", got);
			error_count++;
			return;
		end
		want = awaited.pop_front();
		check_field("node_percent", 32'(want.node_percent), 32'(got.node_percent));
		check_field("node_fault", 32'(want.node_fault), 32'(got.node_fault));
		check_field("read_done", 32'(want.read_done), 32'(got.read_done));
		check_field("read_percent_q8", want.read_percent_q8, got.read_percent_q8);
		check_field("read_fault", 32'(want.read_fault), 32'(got.read_fault));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_w = MATCH_AWARD_RST;
			mismatch_w = MISMATCH_PENALTY_RST;
			open_w = GAP_OPEN_RST;
			extend_w = GAP_EXTEND_RST;
			node_score = '0;
			node_len = '0;
			node_clip = '0;
			read_score = '0;
			read_clip = '0;
			awaited.delete();
			error_count = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				compare_result(result);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MATCH_AWARD: match_w = pwdata[7:0];
					REG_MISMATCH_PENALTY: mismatch_w = pwdata[7:0];
					REG_GAP_OPEN: open_w = pwdata[7:0];
					REG_GAP_EXTEND: extend_w = pwdata[7:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				score_element(item);
			end
			fail_count <= error_count;
			pending <= awaited.size();
		end
	end

endmodule

[tb/tb_cigar_affine_score_percent.sv]
// Top of the testbench for cigar_affine_score_percent: clock, reset, APB weight writes,
// CIGAR element stimulus, result back-pressure and the final verdict.
// Depends on casp_pkg, the block itself and casp_score_monitor.
`timescale 1ns / 1ps

module tb_cigar_affine_score_percent;
	import casp_pkg::*;

	// Operation codes beyond soft clip only add to the node length.
	localparam logic [2:0] OP_LENGTH_ONLY_A = 3'd5;
	localparam logic [2:0] OP_LENGTH_ONLY_B = 3'd6;
	localparam logic [2:0] OP_LENGTH_ONLY_C = 3'd7;
	localparam int LONG_RUN = 130;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	casp_in_t    item;
	logic        result_valid;
	logic        result_stall;
	casp_out_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	int sent_items = 0;
	int tx_gap_pct = 13;
	int rx_stall_pct = 13;
	int hold_requests = 0;

	cigar_affine_score_percent dut (.*);

	casp_score_monitor score_mon (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int hold_done;
		hold_done = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_done != hold_requests) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done++;
			end
			result_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic send_el(input logic [2:0] kind, input int len, input logic node_end,
			input logic read_end, input int read_len);
		casp_in_t el;
		el.op_kind = kind;
		el.op_length = 16'(len);
		el.node_end = node_end;
		el.read_end = read_end;
		el.read_length = 16'(read_len);
		while ($urandom_range(99) < tx_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= el;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent_items++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		logic [23:0] junk;
		junk = 24'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_weights(input logic [7:0] m, input logic [7:0] x, input logic [7:0] o,
			input logic [7:0] e);
		write_reg(REG_MATCH_AWARD, m);
		write_reg(REG_MISMATCH_PENALTY, x);
		write_reg(REG_GAP_OPEN, o);
		write_reg(REG_GAP_EXTEND, e);
	endtask

	// Waits until every result has been taken, then lets a trailing element finish.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_read();
		int nodes;
		int elems;
		int r;
		int len;
		int rl;
		int read_sum;
		logic [2:0] kind;
		logic closes;
		logic last_node;
		read_sum = 0;
		nodes = $urandom_range(1, 4);
		for (int n = 0; n < nodes; n++) begin
			elems = $urandom_range(1, 6);
			for (int e = 0; e < elems; e++) begin
				r = $urandom_range(0, 11);
				kind = (r < 4) ? OP_MATCH : 3'(r - 4);
				len = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 60);
				read_sum += len;
				closes = (e == elems - 1);
				last_node = (n == nodes - 1);
				r = $urandom_range(99);
				if (r < 70) begin
					rl = read_sum + $urandom_range(0, 20);
				end else if (r < 85) begin
					rl = $urandom_range(0, 65535);
				end else begin
					rl = $urandom_range(0, 40);
				end
				if (closes && last_node && $urandom_range(19) == 0) begin
					send_el(kind, len, 1'b0, 1'b1, rl);
				end else begin
					send_el(kind, len, closes, closes && last_node, rl);
				end
			end
		end
	endtask

	task automatic random_phase(input int count);
		int target;
		target = sent_items + count;
		while (sent_items < target) begin
			if ($urandom_range(9) == 0) begin
				send_el(3'($urandom_range(0, 7)), $urandom_range(0, 65535),
					$urandom_range(9) < 3, $urandom_range(9) == 0, $urandom_range(0, 65535));
			end else begin
				send_read();
			end
		end
		settle();
	endtask

	task automatic send_long_node(input logic [2:0] kind, input logic close_read,
			input int read_len);
		for (int i = 0; i < LONG_RUN; i++) begin
			send_el(kind, 65535, i == LONG_RUN - 1, close_read && i == LONG_RUN - 1, read_len);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_el(OP_MATCH, 1, 1'b1, 1'b0, 0);
		send_el(OP_MISMATCH, 65535, 1'b1, 1'b0, 0);
		send_el(OP_INSERT, 0, 1'b1, 1'b0, 0);
		send_el(OP_DELETE, 1, 1'b0, 1'b0, 0);
		send_el(OP_MATCH, 65535, 1'b1, 1'b0, 0);
		send_el(OP_INSERT, 65535, 1'b0, 1'b0, 0);
		send_el(OP_MATCH, 200, 1'b1, 1'b0, 0);
		send_el(OP_SOFTCLIP, 5, 1'b1, 1'b0, 0);
		send_el(OP_MATCH, 0, 1'b1, 1'b0, 0);
		send_el(OP_LENGTH_ONLY_A, 10, 1'b0, 1'b0, 0);
		send_el(OP_LENGTH_ONLY_B, 3, 1'b0, 1'b0, 0);
		send_el(OP_LENGTH_ONLY_C, 65535, 1'b1, 1'b0, 0);
		send_el(OP_MATCH, 20, 1'b0, 1'b1, 100);
		send_el(OP_SOFTCLIP, 30, 1'b0, 1'b0, 0);
		send_el(OP_MATCH, 10, 1'b1, 1'b1, 30);
		send_el(OP_MATCH, 7, 1'b1, 1'b1, 0);
		send_el(OP_SOFTCLIP, 65535, 1'b0, 1'b0, 0);
		send_el(OP_MATCH, 65535, 1'b1, 1'b1, 65535);
		send_el(OP_MATCH, 100, 1'b1, 1'b1, 65535);
		send_el(OP_SOFTCLIP, 10, 1'b0, 1'b0, 0);
		send_el(OP_MATCH, 40, 1'b0, 1'b0, 0);
		send_el(OP_MISMATCH, 2, 1'b1, 1'b0, 0);
		send_el(OP_DELETE, 3, 1'b1, 1'b1, 60);
		settle();
		random_phase(160);

		// Largest weights: node scores saturate both ways and the read total overflows.
		set_weights(8'd255, 8'd255, 8'd255, 8'd255);
		send_long_node(OP_MATCH, 1'b0, 0);
		send_long_node(OP_MATCH, 1'b0, 0);
		send_el(OP_MATCH, 65535, 1'b1, 1'b1, 1000);
		send_long_node(OP_MISMATCH, 1'b1, 500);
		random_phase(150);

		set_weights(8'd0, 8'd0, 8'd0, 8'd0);
		hold_requests++;
		random_phase(160);

		set_weights(8'd255, 8'd0, 8'd255, 8'd0);
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		random_phase(160);
		tx_gap_pct = 13;
		rx_stall_pct = 13;

		repeat (3) begin
			set_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			random_phase(160);
		end

		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
